// ===== hdl/keyed_entry_table_lru_reuse_assert.svh =====
// Assertion macros for the keyed entry table checker.
// Used by the port monitor only; depends on nothing else.
`ifndef KEYED_ENTRY_TABLE_LRU_REUSE_ASSERT_SVH
`define KEYED_ENTRY_TABLE_LRU_REUSE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define KET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define KET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ket_pkg.sv =====
// Shared types and constants for the keyed entry table.
// Used by the cell, the controller, the top level and the monitor.
`timescale 1ns / 1ps
`default_nettype none

package ket_pkg;

    localparam int ENTRIES = 4;
    localparam int SLOT_W  = 2;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;
    localparam int KEY_W   = 32;
    localparam int ID_W    = 8;
    localparam int FRM_W   = 16;
    localparam int STAMP_W = 32;

    localparam int IN_FIELDS_W  = KEY_W + FRM_W + STAMP_W + SLOT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + ID_W + KEY_W + FRM_W + STAMP_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_TOUCH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;
    // Spare code: dropped without a result
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] STAT_FOUND       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEW         = 3'd1;
    localparam logic [STAT_W-1:0] STAT_REUSED      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DELETED     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SLOT_EMPTY  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_LIST_ENTRY  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_TABLE_EMPTY = 3'd6;

    // Contents of one slot as seen by the controller
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [ID_W-1:0]    id;
        logic [FRM_W-1:0]   frames;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               hit_found;
        logic [SLOT_W-1:0]  hit_idx;
        logic               free_found;
        logic [SLOT_W-1:0]  free_idx;
        logic [STAMP_W-1:0] old_stamp;
        logic [SLOT_W-1:0]  old_idx;
    } srch_t;

    // Write command broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  idx;
        logic               fill;
        logic               clear;
        logic [KEY_W-1:0]   key;
        logic [ID_W-1:0]    id;
        logic [FRM_W-1:0]   frames;
        logic [STAMP_W-1:0] stamp;
    } wr_t;

    // One result transfer
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [KEY_W-1:0]   key;
        logic [FRM_W-1:0]   frames;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_SEARCH,
        S_EMIT,
        S_LIST
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/ket_cell.sv =====
// One slot of the table plus one stage of the search chain.
// Depends on ket_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ket_cell
    import ket_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] cell_idx,
    input  wire logic [KEY_W-1:0]  search_key,
    input  wire srch_t             tok_in,
    output srch_t                  tok_out,
    input  wire wr_t               wr,
    output entry_t                 entry
);

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ID_W-1:0]    id_reg;
    logic [FRM_W-1:0]   frames_reg;
    logic [STAMP_W-1:0] stamp_reg;
    srch_t              tok_reg;
    srch_t              tok_next;
    logic               sel;

    assign sel = wr.en && (wr.idx == cell_idx);

    // Fold this slot into the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg)
        begin
            if (!tok_in.hit_found && (key_reg == search_key))
            begin
                tok_next.hit_found = 1'b1;
                tok_next.hit_idx   = cell_idx;
            end
            if (stamp_reg < tok_in.old_stamp)
            begin
                tok_next.old_stamp = stamp_reg;
                tok_next.old_idx   = cell_idx;
            end
        end
        else if (!tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel && wr.fill)
                valid_reg <= 1'b1;
            else if (sel && wr.clear)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && !wr.clear)
        begin
            frames_reg <= wr.frames;
            stamp_reg  <= wr.stamp;
            if (wr.fill)
            begin
                key_reg <= wr.key;
                id_reg  <= wr.id;
            end
        end
    end

    assign tok_out      = tok_reg;
    assign entry.valid  = valid_reg;
    assign entry.key    = key_reg;
    assign entry.id     = id_reg;
    assign entry.frames = frames_reg;
    assign entry.stamp  = stamp_reg;

endmodule

`default_nettype wire

// ===== hdl/ket_ctrl.sv =====
// Sequencer: takes input transfers, launches searches, writes slots
// and drives the output register. Depends on ket_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ket_ctrl
    import ket_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [ACT_W-1:0]       s_tuser,
    input  wire srch_t                  tail_tok,
    input  wire entry_t                 entries [ENTRIES],
    output srch_t                       start_tok,
    output logic [KEY_W-1:0]            search_key,
    output wr_t                         wr,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output res_t                        m_res
);

    state_t             state_reg,    state_next;
    logic [ACT_W-1:0]   act_reg,      act_next;
    logic [KEY_W-1:0]   key_reg,      key_next;
    logic [FRM_W-1:0]   frames_reg,   frames_next;
    logic [STAMP_W-1:0] now_reg,      now_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [STAT_W-1:0]  status_reg,   status_next;
    logic [SLOT_W-1:0]  scan_reg,     scan_next;
    logic [ID_W-1:0]    next_id_reg,  next_id_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg,      out_next;

    logic [ENTRIES-1:0] valid_vec;
    logic               out_free;
    logic               last_here;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
            valid_vec[i] = entries[i].valid;
    end

    assign out_free  = !out_valid_reg || m_tready;
    // No valid slot above the scan position
    assign last_here = ((valid_vec >> scan_reg) >> 1) == '0;

    assign s_tready   = (state_reg == S_IDLE);
    assign search_key = key_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_res      = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        frames_next    = frames_reg;
        now_next       = now_reg;
        res_slot_next  = res_slot_reg;
        status_next    = status_reg;
        scan_next      = scan_reg;
        next_id_next   = next_id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        start_tok      = '0;
        wr             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next      = s_tuser;
                    key_next      = s_tdata[KEY_W-1:0];
                    frames_next   = s_tdata[KEY_W +: FRM_W];
                    now_next      = s_tdata[KEY_W+FRM_W +: STAMP_W];
                    res_slot_next = s_tdata[KEY_W+FRM_W+STAMP_W +: SLOT_W];
                    scan_next     = '0;
                    unique case (s_tuser)
                        ACT_TOUCH:  state_next = S_LAUNCH;
                        ACT_DELETE: state_next = S_EMIT;
                        ACT_LIST:   state_next = S_LIST;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_LAUNCH:
            begin
                start_tok.valid     = 1'b1;
                start_tok.old_stamp = '1;
                state_next          = S_SEARCH;
            end

            S_SEARCH:
            begin
                if (tail_tok.valid)
                begin
                    wr.en     = 1'b1;
                    wr.key    = key_reg;
                    wr.id     = next_id_reg;
                    wr.frames = frames_reg;
                    wr.stamp  = now_reg;
                    if (tail_tok.hit_found)
                    begin
                        wr.idx      = tail_tok.hit_idx;
                        status_next = STAT_FOUND;
                    end
                    else
                    begin
                        wr.fill      = 1'b1;
                        next_id_next = next_id_reg + 1'b1;
                        if (tail_tok.free_found)
                        begin
                            wr.idx      = tail_tok.free_idx;
                            status_next = STAT_NEW;
                        end
                        else
                        begin
                            wr.idx      = tail_tok.old_idx;
                            status_next = STAT_REUSED;
                        end
                    end
                    res_slot_next = wr.idx;
                    state_next    = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.slot   = res_slot_reg;
                    out_next.last   = 1'b1;
                    out_next.id     = entries[res_slot_reg].id;
                    out_next.key    = entries[res_slot_reg].key;
                    out_next.frames = entries[res_slot_reg].frames;
                    out_next.stamp  = entries[res_slot_reg].stamp;
                    if (act_reg == ACT_TOUCH)
                        out_next.status = status_reg;
                    else if (entries[res_slot_reg].valid)
                    begin
                        // Report the freed entry, then drop it
                        out_next.status = STAT_DELETED;
                        wr.en           = 1'b1;
                        wr.idx          = res_slot_reg;
                        wr.clear        = 1'b1;
                    end
                    else
                    begin
                        out_next.status = STAT_SLOT_EMPTY;
                        out_next.id     = '0;
                        out_next.key    = '0;
                        out_next.frames = '0;
                        out_next.stamp  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_LIST:
            begin
                if (valid_vec == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        out_next.status = STAT_TABLE_EMPTY;
                        out_next.last  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (!valid_vec[scan_reg])
                    scan_next = scan_reg + 1'b1;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = STAT_LIST_ENTRY;
                    out_next.slot   = scan_reg;
                    out_next.id     = entries[scan_reg].id;
                    out_next.key    = entries[scan_reg].key;
                    out_next.frames = entries[scan_reg].frames;
                    out_next.stamp  = entries[scan_reg].stamp;
                    out_next.last   = last_here;
                    if (last_here)
                        state_next = S_IDLE;
                    else
                        scan_next = scan_reg + 1'b1;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        frames_reg   <= frames_next;
        now_reg      <= now_next;
        res_slot_reg <= res_slot_next;
        status_reg   <= status_next;
        scan_reg     <= scan_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

// ===== hdl/keyed_entry_table_lru_reuse.sv =====
// Top level of the keyed entry table: a chain of slot cells and the
// sequencer. Depends on ket_pkg, ket_cell and ket_ctrl.
//
// Usage:
// - Input channel s_*: one transfer per action. s_tuser carries the action
//   (touch, delete, list); s_tdata the key, frame count, time and slot.
// - Output channel m_*: m_tuser carries the status, m_tlast marks the
//   final result of an action, m_tdata the slot and entry fields.
// - A touch sends a token down the chain of ENTRIES cells, one cell per
//   cycle, gathering hit, lowest free slot and oldest stamp; the tail
//   token selects the slot to write, the result is loaded into the output
//   register, and only after that is the next input taken.
// - A delete loads its result into the output register from the emit state.
// - A list gives one result per cycle from the output register while the
//   receiver takes them, stepping over empty slots without a result.
// - Actions are handled one at a time; s_tready is high only when idle.
// - A stalled receiver holds the output register; the sequencer waits.
// - Reset empties every slot and restarts the id counter at zero.
`timescale 1ns / 1ps
`default_nettype none

module keyed_entry_table_lru_reuse
    import ket_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [31:0] frequency_hz, [47:32] frame_count, [79:48] now_time,
    // [81:80] target_slot, rest zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  wire logic [ACT_W-1:0]       s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [1:0] slot, [9:2] entry_id, [41:10] entry_frequency,
    // [57:42] entry_frames, [89:58] entry_stamp, rest zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [STAT_W-1:0]           m_tuser,
    output logic                        m_tlast
);

    srch_t            tok [ENTRIES+1];
    entry_t           ent [ENTRIES];
    wr_t              wr;
    logic [KEY_W-1:0] search_key;
    res_t             res;

    ket_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .tail_tok   (tok[ENTRIES]),
        .entries    (ent),
        .start_tok  (tok[0]),
        .search_key (search_key),
        .wr         (wr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_cell
        ket_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (SLOT_W'(gi)),
            .search_key (search_key),
            .tok_in     (tok[gi]),
            .tok_out    (tok[gi+1]),
            .wr         (wr),
            .entry      (ent[gi])
        );
    end

    assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                      res.stamp, res.frames, res.key, res.id, res.slot};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// ===== hdl/ket_monitor.sv =====
// Port-level checks for the keyed entry table, bound to the top level.
// Depends on ket_pkg and keyed_entry_table_lru_reuse_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_entry_table_lru_reuse_assert.svh"

module ket_monitor
    import ket_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tready,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [STAT_W-1:0]      m_tuser,
    input  wire logic                   m_tlast
);

    logic                          out_stall;
    logic                          mid_list;
    logic                          single_res;
    logic                          empty_res;
    logic                          entry_zero;
    logic [OUT_TDATA_W+STAT_W:0]   out_word;

    assign out_stall  = m_tvalid && !m_tready;
    assign mid_list   = m_tvalid && !m_tlast;
    assign single_res = m_tvalid && (m_tuser != STAT_LIST_ENTRY);
    assign empty_res  = m_tvalid && ((m_tuser == STAT_SLOT_EMPTY) ||
                                     (m_tuser == STAT_TABLE_EMPTY));
    assign entry_zero = (m_tdata[OUT_FIELDS_W-1:SLOT_W] == '0);
    assign out_word   = {m_tlast, m_tuser, m_tdata};

    `KET_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid, "output dropped while stalled")

    `KET_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_word), "data moved in stall")

    // A list still running keeps the input side closed
    `KET_ASSERT_NOW(a_busy_in_list, clk, rst_n, mid_list, !s_tready, "input open during a list")

    `KET_ASSERT_NOW(a_single_last, clk, rst_n, single_res, m_tlast, "single result without last")

    `KET_ASSERT_NOW(a_empty_zero, clk, rst_n, empty_res, entry_zero, "entry data on empty result")

endmodule

bind keyed_entry_table_lru_reuse ket_monitor u_ket_monitor (.*);

`default_nettype wire

// ===== tb/sv/tb_keyed_entry_table_lru_reuse.sv =====
// Self-checking testbench for the keyed entry table with timestamp LRU reuse.
// Holds a scoreboard class that predicts every result and checks the output stream.
// Depends on ket_pkg and the keyed_entry_table_lru_reuse top level.
`timescale 1ns / 1ps

class lru_table_scoreboard;
    bit                          tbl_valid  [ket_pkg::ENTRIES];
    logic [ket_pkg::KEY_W-1:0]   tbl_key    [ket_pkg::ENTRIES];
    logic [ket_pkg::ID_W-1:0]    tbl_id     [ket_pkg::ENTRIES];
    logic [ket_pkg::FRM_W-1:0]   tbl_frames [ket_pkg::ENTRIES];
    logic [ket_pkg::STAMP_W-1:0] tbl_stamp  [ket_pkg::ENTRIES];
    logic [ket_pkg::ID_W-1:0]    id_counter;
    ket_pkg::res_t               pending_results [$];
    int                          fail_count;

    function new();
        for (int i = 0; i < ket_pkg::ENTRIES; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_id[i]     = '0;
            tbl_frames[i] = '0;
            tbl_stamp[i]  = '0;
        end
        id_counter = '0;
        fail_count = 0;
    endfunction

    // Queue one result; entry fields come from the slot when fill is set
    function void queue_entry(logic [ket_pkg::STAT_W-1:0] status, int idx, bit fill, bit last);
        ket_pkg::res_t r;
        r = '0;
        r.status = status;
        r.slot   = idx[ket_pkg::SLOT_W-1:0];
        if (fill)
        begin
            r.id     = tbl_id[idx];
            r.key    = tbl_key[idx];
            r.frames = tbl_frames[idx];
            r.stamp  = tbl_stamp[idx];
        end
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function void note_action(logic [ket_pkg::ACT_W-1:0] act,
                              logic [ket_pkg::KEY_W-1:0] key,
                              logic [ket_pkg::FRM_W-1:0] frames,
                              logic [ket_pkg::STAMP_W-1:0] now,
                              logic [ket_pkg::SLOT_W-1:0] target);
        int                          hit;
        int                          free_idx;
        int                          old_idx;
        int                          last_valid;
        logic [ket_pkg::STAMP_W-1:0] oldest;
        logic [ket_pkg::STAT_W-1:0]  status;
        hit        = ket_pkg::ENTRIES;
        free_idx   = ket_pkg::ENTRIES;
        old_idx    = 0;
        last_valid = ket_pkg::ENTRIES;
        oldest     = '1;
        case (act)
            ket_pkg::ACT_TOUCH:
            begin
                for (int i = 0; i < ket_pkg::ENTRIES; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        if (hit == ket_pkg::ENTRIES && tbl_key[i] == key)
                            hit = i;
                    end
                    else if (free_idx == ket_pkg::ENTRIES)
                        free_idx = i;
                end
                if (hit < ket_pkg::ENTRIES)
                    status = ket_pkg::STAT_FOUND;
                else
                begin
                    if (free_idx < ket_pkg::ENTRIES)
                    begin
                        hit    = free_idx;
                        status = ket_pkg::STAT_NEW;
                    end
                    else
                    begin
                        // strict compare: the lowest slot wins a tie
                        for (int i = 0; i < ket_pkg::ENTRIES; i++)
                        begin
                            if (tbl_stamp[i] < oldest)
                            begin
                                oldest  = tbl_stamp[i];
                                old_idx = i;
                            end
                        end
                        hit    = old_idx;
                        status = ket_pkg::STAT_REUSED;
                    end
                    tbl_valid[hit] = 1'b1;
                    tbl_key[hit]   = key;
                    tbl_id[hit]    = id_counter;
                    id_counter     = id_counter + 1'b1;
                end
                tbl_frames[hit] = frames;
                tbl_stamp[hit]  = now;
                queue_entry(status, hit, 1'b1, 1'b1);
            end
            ket_pkg::ACT_DELETE:
            begin
                if (tbl_valid[target])
                begin
                    queue_entry(ket_pkg::STAT_DELETED, target, 1'b1, 1'b1);
                    tbl_valid[target] = 1'b0;
                end
                else
                    queue_entry(ket_pkg::STAT_SLOT_EMPTY, target, 1'b0, 1'b1);
            end
            ket_pkg::ACT_LIST:
            begin
                for (int i = 0; i < ket_pkg::ENTRIES; i++)
                    if (tbl_valid[i])
                        last_valid = i;
                if (last_valid == ket_pkg::ENTRIES)
                    queue_entry(ket_pkg::STAT_TABLE_EMPTY, 0, 1'b0, 1'b1);
                else
                    for (int i = 0; i < ket_pkg::ENTRIES; i++)
                        if (tbl_valid[i])
                            queue_entry(ket_pkg::STAT_LIST_ENTRY, i, 1'b1, i == last_valid);
            end
            default:
                ; // unused code: no result, no change
        endcase
    endfunction

    function void check_result(ket_pkg::res_t got);
        ket_pkg::res_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: status %0d slot %0d", got.status, got.slot);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.slot !== want.slot)
        begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            fail_count++;
        end
        if (got.id !== want.id)
        begin
            $error("entry_id: expected %0d, actual %0d", want.id, got.id);
            fail_count++;
        end
        if (got.key !== want.key)
        begin
            $error("entry_frequency: expected %h, actual %h", want.key, got.key);
            fail_count++;
        end
        if (got.frames !== want.frames)
        begin
            $error("entry_frames: expected %h, actual %h", want.frames, got.frames);
            fail_count++;
        end
        if (got.stamp !== want.stamp)
        begin
            $error("entry_stamp: expected %h, actual %h", want.stamp, got.stamp);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endfunction
endclass

module tb_keyed_entry_table_lru_reuse;
    import ket_pkg::*;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACT_W-1:0]       s_tuser  = '0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire [STAT_W-1:0]       m_tuser;
    wire                    m_tlast;

    lru_table_scoreboard    sb = new();
    bit                     idle_en = 1'b1;
    int                     rx_hold = 0;
    logic [STAMP_W-1:0]     clock_now = '0;
    logic [KEY_W-1:0]       key_pool [6];

    keyed_entry_table_lru_reuse DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall in short bursts while idling is enabled
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // Sample both channels on the edge at which each transfer completes
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_action(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[79:48],
                               s_tdata[81:80]);
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.slot   = m_tdata[1:0];
                got.id     = m_tdata[9:2];
                got.key    = m_tdata[41:10];
                got.frames = m_tdata[57:42];
                got.stamp  = m_tdata[89:58];
                got.last   = m_tlast;
                sb.check_result(got);
            end
        end
    end

    task automatic send_action(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [FRM_W-1:0] frames, input logic [STAMP_W-1:0] now,
                               input logic [SLOT_W-1:0] target);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= IN_TDATA_W'({target, now, frames, key});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic touch(input logic [KEY_W-1:0] key, input logic [FRM_W-1:0] frames,
                         input logic [STAMP_W-1:0] now);
        send_action(ACT_TOUCH, key, frames, now, SLOT_W'($urandom));
    endtask

    task automatic delete_slot(input logic [SLOT_W-1:0] target);
        send_action(ACT_DELETE, $urandom, FRM_W'($urandom), $urandom, target);
    endtask

    task automatic list_all();
        send_action(ACT_LIST, $urandom, FRM_W'($urandom), $urandom, SLOT_W'($urandom));
    endtask

    // Hold the sender until every predicted result has been seen
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly advancing time with frequent ties, now and then a jump or an extreme
    function automatic logic [STAMP_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 3);
        return clock_now;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 1) == 0)
            return key_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    initial
    begin
        int pick;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, hit, fill, reuse and tie, deletes
        list_all();
        delete_slot(2'd0);
        delete_slot(2'd3);
        touch(32'h0000_0000, 16'h0000, 32'h0000_0000);
        touch(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        touch(32'h0000_0000, 16'hFFFF, 32'h0000_0005);
        touch(32'h1234_5678, 16'h5A5A, 32'hFFFF_FFFF);
        touch(32'h8000_0001, 16'hA5A5, 32'hFFFF_FFFF);
        list_all();
        touch(32'hA5A5_A5A5, 16'h0001, 32'h0000_000A);
        // equal stamps everywhere: the lowest slot must be reused
        touch(32'hA5A5_A5A5, 16'h0002, 32'h0000_0064);
        touch(32'hFFFF_FFFF, 16'h0003, 32'h0000_0064);
        touch(32'h1234_5678, 16'h0004, 32'h0000_0064);
        touch(32'h8000_0001, 16'h0005, 32'h0000_0064);
        touch(32'h0000_0001, 16'h0006, 32'h0000_0064);
        delete_slot(2'd2);
        delete_slot(2'd2);
        list_all();
        send_action(ACT_UNUSED, $urandom, FRM_W'($urandom), $urandom, SLOT_W'($urandom));
        touch(32'h7FFF_FFFF, 16'h8000, 32'h8000_0000);
        for (int i = 0; i < ENTRIES; i++)
            delete_slot(i[SLOT_W-1:0]);
        list_all();
        hold_until_drained();

        // Fresh keys until the id counter has wrapped past 255
        for (int n = 0; n < 252; n++)
        begin
            if (n == 100)
                hold_until_drained();
            touch($urandom, FRM_W'($urandom), pick_time());
        end

        // Mixed traffic to close; no idling on either side
        idle_en = 1'b0;
        for (int n = 0; n < 20; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                touch(pick_key(), FRM_W'($urandom), pick_time());
            else if (pick < 15)
                delete_slot(SLOT_W'($urandom));
            else if (pick < 19)
                list_all();
            else
                send_action(ACT_UNUSED, $urandom, FRM_W'($urandom), $urandom,
                            SLOT_W'($urandom));
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 8) @(posedge clk);
        if (sb.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
